/* hw/rtl/lost_pkg.sv */
// Shared types and constants of the line-of-sight segment test.
`timescale 1ns / 1ps

package lost_pkg;

	localparam int RADIUS_BITS  = 31;
	localparam int NUM_REGS     = 5;
	localparam int REG_IDX_BITS = 3;
	localparam int NUM_PROD     = 14;
	localparam int NUM_ORIENT   = 4;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_OBSERVER_X  = 3'd0,
		REG_OBSERVER_Y  = 3'd1,
		REG_TARGET_X    = 3'd2,
		REG_TARGET_Y    = 3'd3,
		REG_SIGHT_RADIUS = 3'd4
	} reg_idx_t;

	// Per-request control bits carried down the pipeline.
	typedef struct packed {
		logic present;
		logic last;
		logic same;
	} item_flags_t;

	// Sign of one orientation cross product.
	typedef struct packed {
		logic neg;
		logic zero;
	} orient_t;

	// True when both orientations are nonzero and of opposite sign.
	function automatic logic strictly_opposite(orient_t a, orient_t b);
		return !a.zero && !b.zero && (a.neg != b.neg);
	endfunction

endpackage

/* hw/rtl/lost_if.sv */
// Valid/ready channel interfaces for segment requests and verdicts.
`timescale 1ns / 1ps

interface lost_seg_if #(
	parameter int COORD_BITS = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] seg_start_x;
	logic signed [COORD_BITS-1:0] seg_start_y;
	logic signed [COORD_BITS-1:0] seg_end_x;
	logic signed [COORD_BITS-1:0] seg_end_y;
	logic                         segment_present;
	logic                         last_segment;

	modport source (
		output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		output segment_present, last_segment,
		input  ready
	);
	modport sink (
		input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		input  segment_present, last_segment,
		output ready
	);
endinterface

interface lost_verdict_if ();
	logic valid;
	logic ready;
	logic line_clear;
	logic segment_blocks;
	logic query_done;

	modport source (
		output valid, line_clear, segment_blocks, query_done,
		input  ready
	);
	modport sink (
		input  valid, line_clear, segment_blocks, query_done,
		output ready
	);
endinterface

/* hw/rtl/line_of_sight_segment_test_unit.sv */
// Line-of-sight segment test: tests a stream of occluder segments against the
// sight line from the configured observer to the configured target and keeps a
// sticky blocked flag per query. One request enters per cycle unless a stalled
// verdict output has backed up every stage of the five-stage pipeline (input
// differences, partial products, full products, cross and dot sums, verdict),
// whose stages each advance whenever the stage after them is empty or moving,
// so requests fill empty stages while a finished verdict waits at the output. A
// segment blocks on a proper crossing or on a collinear overlap of positive
// length; touches at an endpoint do not block. The verdict is clear when the
// observer equals the target, and never clear when the target lies beyond the
// sight radius. The item marked last ends the query and clears the flag.
// Registers (APB, 4-byte steps, 8-byte steps when coordinates exceed 32 bits):
// observer_x, observer_y, target_x, target_y, sight_radius; all reset to zero.
// Write them only while no request is in flight.
`timescale 1ns / 1ps

module line_of_sight_segment_test_unit #(
	parameter int  COORD_BITS = 32,
	localparam int PDATA_BITS = (COORD_BITS > 32) ? 64 : 32,
	localparam int PADDR_BITS = $clog2(lost_pkg::NUM_REGS * (PDATA_BITS / 8))
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready,
	lost_seg_if.sink              seg,
	lost_verdict_if.source        verdict
);
	import lost_pkg::*;

	localparam int DW       = COORD_BITS + 1;     // coordinate difference
	localparam int PW       = 2 * DW;             // one product
	localparam int SW       = PW + 1;             // sum or difference of two products
	localparam int RSQ_BITS = 2 * RADIUS_BITS;    // squared radius, unsigned
	localparam int CW       = (SW > RSQ_BITS + 1) ? SW : RSQ_BITS + 1;

	// Product slots: four cross products as pairs, then the two dot products
	// and the squared length of the sight line.
	localparam int P_TA  = 8;
	localparam int P_TB  = 10;
	localparam int P_LEN = 12;

	// ---------------------------------------------------------------- config
	logic signed [COORD_BITS-1:0]  observer_x;
	logic signed [COORD_BITS-1:0]  observer_y;
	logic signed [COORD_BITS-1:0]  target_x;
	logic signed [COORD_BITS-1:0]  target_y;
	logic [RADIUS_BITS-1:0]        sight_radius;

	lost_cfg #(
		.COORD_BITS (COORD_BITS),
		.PDATA_BITS (PDATA_BITS),
		.PADDR_BITS (PADDR_BITS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.observer_x   (observer_x),
		.observer_y   (observer_y),
		.target_x     (target_x),
		.target_y     (target_y),
		.sight_radius (sight_radius)
	);

	// ---------------------------------------------------------- flow control
	// Each stage advances when it is empty or when the next one advances.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	assign adv_s5    = !v_s5 || verdict.ready;
	assign adv_s4    = !v_s4 || adv_s5;
	assign adv_s3    = !v_s3 || adv_s4;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign seg.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= seg.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	// ------------------------------------------------- stage 1: differences
	logic signed [DW-1:0] px, py, qx, qy, ax, ay, bx, by;

	assign px = DW'(observer_x);
	assign py = DW'(observer_y);
	assign qx = DW'(target_x);
	assign qy = DW'(target_y);
	assign ax = DW'(seg.seg_start_x);
	assign ay = DW'(seg.seg_start_y);
	assign bx = DW'(seg.seg_end_x);
	assign by = DW'(seg.seg_end_y);

	logic signed [DW-1:0] dx_s1, dy_s1;       // target - observer
	logic signed [DW-1:0] ap_x_s1, ap_y_s1;   // start - observer
	logic signed [DW-1:0] bp_x_s1, bp_y_s1;   // end - observer
	logic signed [DW-1:0] ba_x_s1, ba_y_s1;   // end - start
	logic signed [DW-1:0] pa_x_s1, pa_y_s1;   // observer - start
	logic signed [DW-1:0] qa_x_s1, qa_y_s1;   // target - start
	logic [RADIUS_BITS-1:0] rad_s1;
	item_flags_t            flags_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dx_s1          <= qx - px;
			dy_s1          <= qy - py;
			ap_x_s1        <= ax - px;
			ap_y_s1        <= ay - py;
			bp_x_s1        <= bx - px;
			bp_y_s1        <= by - py;
			ba_x_s1        <= bx - ax;
			ba_y_s1        <= by - ay;
			pa_x_s1        <= px - ax;
			pa_y_s1        <= py - ay;
			qa_x_s1        <= qx - ax;
			qa_y_s1        <= qy - ay;
			rad_s1         <= sight_radius;
			flags_s1.present <= seg.segment_present;
			flags_s1.last    <= seg.last_segment;
			flags_s1.same    <= (observer_x == target_x) && (observer_y == target_y);
		end
	end

	// ------------------------------------------ stages 2 and 3: products
	logic signed [DW-1:0] mul_a [NUM_PROD];
	logic signed [DW-1:0] mul_b [NUM_PROD];
	logic signed [PW-1:0] prod_s3 [NUM_PROD];

	// Orientation of start and end against the sight line.
	assign mul_a[0]  = dx_s1;   assign mul_b[0]  = ap_y_s1;
	assign mul_a[1]  = dy_s1;   assign mul_b[1]  = ap_x_s1;
	assign mul_a[2]  = dx_s1;   assign mul_b[2]  = bp_y_s1;
	assign mul_a[3]  = dy_s1;   assign mul_b[3]  = bp_x_s1;
	// Orientation of observer and target against the occluder.
	assign mul_a[4]  = ba_x_s1; assign mul_b[4]  = pa_y_s1;
	assign mul_a[5]  = ba_y_s1; assign mul_b[5]  = pa_x_s1;
	assign mul_a[6]  = ba_x_s1; assign mul_b[6]  = qa_y_s1;
	assign mul_a[7]  = ba_y_s1; assign mul_b[7]  = qa_x_s1;
	// Projections of the endpoints onto the sight line, and its squared length.
	assign mul_a[8]  = ap_x_s1; assign mul_b[8]  = dx_s1;
	assign mul_a[9]  = ap_y_s1; assign mul_b[9]  = dy_s1;
	assign mul_a[10] = bp_x_s1; assign mul_b[10] = dx_s1;
	assign mul_a[11] = bp_y_s1; assign mul_b[11] = dy_s1;
	assign mul_a[12] = dx_s1;   assign mul_b[12] = dx_s1;
	assign mul_a[13] = dy_s1;   assign mul_b[13] = dy_s1;

	for (genvar i = 0; i < NUM_PROD; i++) begin : g_mul
		lost_mul #(
			.W (DW)
		) u_mul (
			.clk   (clk),
			.en_s2 (adv_s2),
			.en_s3 (adv_s3),
			.a     (mul_a[i]),
			.b     (mul_b[i]),
			.p     (prod_s3[i])
		);
	end

	logic [RSQ_BITS-1:0] rad_sq_s2, rad_sq_s3;
	item_flags_t         flags_s2, flags_s3;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rad_sq_s2 <= RSQ_BITS'(rad_s1) * RSQ_BITS'(rad_s1);
			flags_s2  <= flags_s1;
		end
		if (adv_s3) begin
			rad_sq_s3 <= rad_sq_s2;
			flags_s3  <= flags_s2;
		end
	end

	// ------------------------------------- stage 4: cross signs and sums
	logic signed [SW-1:0] cross_w [NUM_ORIENT];
	orient_t              orient_w [NUM_ORIENT];

	always_comb begin
		for (int k = 0; k < NUM_ORIENT; k++) begin
			cross_w[k]       = SW'(prod_s3[2*k]) - SW'(prod_s3[2*k+1]);
			orient_w[k].neg  = cross_w[k][SW-1];
			orient_w[k].zero = (cross_w[k] == '0);
		end
	end

	orient_t              orient_s4 [NUM_ORIENT];
	logic signed [SW-1:0] ta_s4, tb_s4, len_s4;
	logic [RSQ_BITS-1:0]  rad_sq_s4;
	item_flags_t          flags_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			orient_s4 <= orient_w;
			ta_s4     <= SW'(prod_s3[P_TA])  + SW'(prod_s3[P_TA+1]);
			tb_s4     <= SW'(prod_s3[P_TB])  + SW'(prod_s3[P_TB+1]);
			len_s4    <= SW'(prod_s3[P_LEN]) + SW'(prod_s3[P_LEN+1]);
			rad_sq_s4 <= rad_sq_s3;
			flags_s4  <= flags_s3;
		end
	end

	// ------------------------------------------------- stage 5: verdict
	logic crossing, collinear, overlap, blocks_w, far_w, blocked_w, clear_w;
	logic ta_pos, tb_pos;

	// Clipped overlap [max(min,0), min(max,len)] is nonempty exactly when the
	// projections differ, the lower one is short of the target and the upper
	// one is past the observer.
	assign ta_pos    = !ta_s4[SW-1] && (ta_s4 != '0);
	assign tb_pos    = !tb_s4[SW-1] && (tb_s4 != '0);
	assign overlap   = (ta_s4 != tb_s4) && ((ta_s4 < len_s4) || (tb_s4 < len_s4)) &&
	                   (ta_pos || tb_pos);
	assign collinear = orient_s4[0].zero && orient_s4[1].zero;
	assign crossing  = strictly_opposite(orient_s4[0], orient_s4[1]) &&
	                   strictly_opposite(orient_s4[2], orient_s4[3]);
	assign blocks_w  = flags_s4.present && !flags_s4.same &&
	                   (crossing || (collinear && overlap));
	assign far_w     = CW'(len_s4) > $signed(CW'(rad_sq_s4));

	logic blocked_q;

	assign blocked_w = blocked_q || blocks_w;
	assign clear_w   = flags_s4.same || (!far_w && !blocked_w);

	// Update the sticky flag as the request enters the last stage, so that
	// requests see it in order; drop it at the end of a query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= 1'b0;
		end else if (adv_s5 && v_s4) begin
			blocked_q <= flags_s4.last ? 1'b0 : blocked_w;
		end
	end

	logic line_clear_s5, segment_blocks_s5, query_done_s5;

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			line_clear_s5     <= clear_w;
			segment_blocks_s5 <= blocks_w;
			query_done_s5     <= flags_s4.last;
		end
	end

	// Hold the verdict until it is taken.
	assign verdict.valid          = v_s5;
	assign verdict.line_clear     = line_clear_s5;
	assign verdict.segment_blocks = segment_blocks_s5;
	assign verdict.query_done     = query_done_s5;

endmodule

/* hw/rtl/lost_cfg.sv */
// APB register file holding observer, target and sight radius.
`timescale 1ns / 1ps

module lost_cfg #(
	parameter int COORD_BITS = 32,
	parameter int PDATA_BITS = 32,
	parameter int PADDR_BITS = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [PADDR_BITS-1:0]               paddr,
	input  logic [PDATA_BITS-1:0]               pwdata,
	output logic [PDATA_BITS-1:0]               prdata,
	output logic                                pready,
	output logic signed [COORD_BITS-1:0]        observer_x,
	output logic signed [COORD_BITS-1:0]        observer_y,
	output logic signed [COORD_BITS-1:0]        target_x,
	output logic signed [COORD_BITS-1:0]        target_y,
	output logic [lost_pkg::RADIUS_BITS-1:0]    sight_radius
);
	import lost_pkg::*;

	localparam int STEP_LOG = $clog2(PDATA_BITS / 8);

	reg_idx_t                     idx;
	logic                         wr_en;
	logic signed [COORD_BITS-1:0] wr_coord;

	assign idx      = reg_idx_t'(paddr[PADDR_BITS-1:STEP_LOG]);
	assign wr_en    = psel && penable && pwrite;
	assign wr_coord = pwdata[COORD_BITS-1:0];
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			observer_x   <= '0;
			observer_y   <= '0;
			target_x     <= '0;
			target_y     <= '0;
			sight_radius <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_OBSERVER_X:   observer_x   <= wr_coord;
				REG_OBSERVER_Y:   observer_y   <= wr_coord;
				REG_TARGET_X:     target_x     <= wr_coord;
				REG_TARGET_Y:     target_y     <= wr_coord;
				REG_SIGHT_RADIUS: sight_radius <= pwdata[RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_OBSERVER_X:   prdata = PDATA_BITS'(observer_x);
			REG_OBSERVER_Y:   prdata = PDATA_BITS'(observer_y);
			REG_TARGET_X:     prdata = PDATA_BITS'(target_x);
			REG_TARGET_Y:     prdata = PDATA_BITS'(target_y);
			REG_SIGHT_RADIUS: prdata = PDATA_BITS'(sight_radius);
			default:          prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/lost_mul.sv */
// Two-stage signed multiplier built from four half-width partial products.
`timescale 1ns / 1ps

module lost_mul #(
	parameter int W = 33
) (
	input  logic                  clk,
	input  logic                  en_s2,
	input  logic                  en_s3,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	localparam int H  = (W + 1) / 2;
	localparam int L  = W - H;
	localparam int PW = 2 * W;

	logic signed [H:0]   a_lo;
	logic signed [H:0]   b_lo;
	logic signed [L-1:0] a_hi;
	logic signed [L-1:0] b_hi;

	logic signed [2*H+1:0] ll_s2;
	logic signed [H+L:0]   lh_s2;
	logic signed [H+L:0]   hl_s2;
	logic signed [2*L-1:0] hh_s2;

	// Split each operand into an unsigned low half and a signed high half.
	assign a_lo = $signed({1'b0, a[H-1:0]});
	assign b_lo = $signed({1'b0, b[H-1:0]});
	assign a_hi = a[W-1:H];
	assign b_hi = b[W-1:H];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ll_s2 <= a_lo * b_lo;
			lh_s2 <= a_lo * b_hi;
			hl_s2 <= a_hi * b_lo;
			hh_s2 <= a_hi * b_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			p <= (PW'(hh_s2) <<< (2 * H)) + ((PW'(lh_s2) + PW'(hl_s2)) <<< H) + PW'(ll_s2);
		end
	end

endmodule

/* hw/rtl/lost_chk.sv */
// Port-level checker for the line-of-sight segment test, bound to the top level.
`timescale 1ns / 1ps

module lost_chk (
	input logic clk,
	input logic arst_n,
	input logic seg_ready,
	input logic out_valid,
	input logic out_ready,
	input logic line_clear,
	input logic segment_blocks,
	input logic query_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(line_clear) && $stable(segment_blocks) && $stable(query_done))
		else $error("verdict payload changed while stalled");

	a_block_not_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segment_blocks |-> !line_clear)
		else $error("blocking segment reported with a clear line");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> seg_ready)
		else $error("segment request refused with no verdict waiting");

endmodule

bind line_of_sight_segment_test_unit lost_chk u_lost_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.seg_ready      (seg.ready),
	.out_valid      (verdict.valid),
	.out_ready      (verdict.ready),
	.line_clear     (verdict.line_clear),
	.segment_blocks (verdict.segment_blocks),
	.query_done     (verdict.query_done)
);

/* verif/line_of_sight_segment_test_unit_tb.sv */
// Self-checking testbench for the line-of-sight segment test unit.
`timescale 1ns / 1ps

module line_of_sight_segment_test_unit_tb;
	import lost_pkg::*;

	localparam int CLK_PERIOD      = 20;
	localparam int ADDR_BITS       = $clog2(NUM_REGS * 4);
	localparam int ITEMS_PER_PHASE = 50;
	localparam int HOLD_AFTER      = 100;    // requests sent before the long output stall
	localparam int HOLD_CYCLES     = 200;
	localparam int DRAIN_CYCLES    = 20;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int REPORT_LIMIT    = 10;

	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic               present;
		logic               last;
	} seg_req_t;

	typedef struct packed {
		logic line_clear;
		logic segment_blocks;
		logic query_done;
	} verdict_t;

	typedef enum logic {
		ROW_SEG,
		ROW_CFG
	} row_kind_t;

	// One line of the directed plan: either a register write or a request, the
	// latter with a hand-typed verdict when typed is set.
	typedef struct packed {
		row_kind_t          kind;
		reg_idx_t           idx;
		logic [31:0]        value;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic               present;
		logic               last;
		logic               typed;
		logic               exp_clear;
		logic               exp_blocks;
	} plan_row_t;

	localparam int NUM_PLAN_ROWS = 35;

	// Columns: kind, register, value | sx, sy, ex, ey, present, last | typed, clear, blocks
	localparam plan_row_t DIRECTED_PLAN [NUM_PLAN_ROWS] = '{
		// after reset observer equals target: always clear, never blocking
		'{ROW_SEG, REG_OBSERVER_X, 0, C_MIN, C_MIN, C_MAX, C_MAX, 1, 0, 1, 1, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0},
		// sight line (0,0) -> (100,0), widest radius
		'{ROW_CFG, REG_TARGET_X, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_SIGHT_RADIUS, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		// proper crossing, then an empty request still sees the sticky flag
		'{ROW_SEG, REG_OBSERVER_X, 0, 50, -10, 50, 10, 1, 0, 1, 0, 1},
		'{ROW_SEG, REG_OBSERVER_X, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0},
		// T junction on the line and endpoint touch at the target
		'{ROW_SEG, REG_OBSERVER_X, 0, 50, 0, 50, 10, 1, 1, 1, 1, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, 100, 0, 120, 10, 1, 1, 1, 1, 0},
		// collinear: overlap, touch at the target, full cover, degenerate point
		'{ROW_SEG, REG_OBSERVER_X, 0, 90, 0, 200, 0, 1, 1, 1, 0, 1},
		'{ROW_SEG, REG_OBSERVER_X, 0, 100, 0, 200, 0, 1, 1, 1, 1, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, -10, 0, 110, 0, 1, 1, 1, 0, 1},
		'{ROW_SEG, REG_OBSERVER_X, 0, 50, 0, 50, 0, 1, 1, 1, 1, 0},
		// extreme coordinates: diagonal through the observer, vertical crossing
		'{ROW_SEG, REG_OBSERVER_X, 0, C_MIN, C_MIN, C_MAX, C_MAX, 1, 1, 1, 1, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, 50, C_MIN, 50, C_MAX, 1, 1, 1, 0, 1},
		// oblique pair, left to the predictor
		'{ROW_SEG, REG_OBSERVER_X, 0, 10, -30, 70, 45, 1, 0, 0, 0, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, -20, 5, 130, 7, 1, 1, 0, 0, 0},
		// target just out of range: never clear, blocking still reported
		'{ROW_CFG, REG_SIGHT_RADIUS, 99, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, 50, -10, 50, 10, 1, 1, 1, 0, 1},
		// target exactly at the radius counts as in range
		'{ROW_CFG, REG_SIGHT_RADIUS, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0},
		// corner to corner sight line
		'{ROW_CFG, REG_OBSERVER_X, C_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_OBSERVER_Y, C_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_TARGET_X, C_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_TARGET_Y, C_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, C_MIN, C_MAX, C_MAX, C_MIN, 1, 1, 1, 0, 1},
		'{ROW_SEG, REG_OBSERVER_X, 0, C_MIN, C_MIN, C_MAX, C_MAX, 1, 1, 1, 0, 1},
		'{ROW_SEG, REG_OBSERVER_X, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0},
		// observer equals target away from the origin, zero radius
		'{ROW_CFG, REG_OBSERVER_X, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_OBSERVER_Y, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_TARGET_X, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_TARGET_Y, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, 0, 5, 10, 5, 1, 1, 1, 1, 0},
		'{ROW_CFG, REG_SIGHT_RADIUS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_SEG, REG_OBSERVER_X, 0, 0, 0, 9, 9, 1, 1, 1, 1, 0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	lost_seg_if #(.COORD_BITS(32)) seg_ch ();
	lost_verdict_if                verdict_ch ();

	line_of_sight_segment_test_unit #(
		.COORD_BITS(32)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seg     (seg_ch),
		.verdict (verdict_ch)
	);

	// Shadow of the geometry registers and the sticky flag of the open query.
	logic signed [31:0] obs_x, obs_y, tgt_x, tgt_y;
	logic [30:0]        sight_radius;
	logic               blocked_flag;

	verdict_t    expected_verdicts [$];
	verdict_t    seen_verdict;
	verdict_t    due_verdict;
	int unsigned mismatches    = 0;
	int unsigned requests_sent = 0;
	int unsigned cycle_count   = 0;
	int unsigned src_idle_pct  = 25;
	int unsigned sink_idle_pct = 77;

	initial begin
		obs_x        = '0;
		obs_y        = '0;
		tgt_x        = '0;
		tgt_y        = '0;
		sight_radius = '0;
		blocked_flag = 1'b0;
	end

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Sign of the cross product (q - p) x (r - p), exact at 128 bits.
	function automatic int orientation(wide_t px, wide_t py, wide_t qx, wide_t qy,
			wide_t rx, wide_t ry);
		wide_t c;
		c = (qx - px) * (ry - py) - (qy - py) * (rx - px);
		if (c < 0)
			return -1;
		return (c == 0) ? 0 : 1;
	endfunction

	// Blocking test of one segment against the closed sight segment: proper
	// crossing, or collinear overlap of positive length once both are projected
	// on the sight direction and clamped to it.
	function automatic logic crosses_sight(seg_req_t s);
		wide_t px, py, qx, qy, ax, ay, bx, by;
		wide_t dx, dy, ta, tb, span, lo, hi;
		int    o1, o2, o3, o4;
		px = obs_x;
		py = obs_y;
		qx = tgt_x;
		qy = tgt_y;
		ax = $signed(s.sx);
		ay = $signed(s.sy);
		bx = $signed(s.ex);
		by = $signed(s.ey);
		o1 = orientation(px, py, qx, qy, ax, ay);
		o2 = orientation(px, py, qx, qy, bx, by);
		o3 = orientation(ax, ay, bx, by, px, py);
		o4 = orientation(ax, ay, bx, by, qx, qy);
		if (o1 * o2 < 0 && o3 * o4 < 0)
			return 1'b1;
		if (o1 != 0 || o2 != 0)
			return 1'b0;
		dx   = qx - px;
		dy   = qy - py;
		ta   = (ax - px) * dx + (ay - py) * dy;
		tb   = (bx - px) * dx + (by - py) * dy;
		span = dx * dx + dy * dy;
		lo   = (ta < tb) ? ta : tb;
		hi   = (ta < tb) ? tb : ta;
		if (lo < 0)
			lo = 0;
		if (hi > span)
			hi = span;
		return lo < hi;
	endfunction

	// Verdict of one request; advances the sticky flag.
	function automatic verdict_t predict_verdict(seg_req_t s);
		verdict_t v;
		wide_t    ox, oy, tx, ty, dx, dy, reach;
		v            = '0;
		v.query_done = s.last;
		if (obs_x == tgt_x && obs_y == tgt_y) begin
			v.line_clear = 1'b1;
		end else begin
			ox    = obs_x;
			oy    = obs_y;
			tx    = tgt_x;
			ty    = tgt_y;
			dx    = tx - ox;
			dy    = ty - oy;
			reach = {97'd0, sight_radius};
			if (s.present)
				v.segment_blocks = crosses_sight(s);
			if (v.segment_blocks)
				blocked_flag = 1'b1;
			v.line_clear = !(dx * dx + dy * dy > reach * reach) && !blocked_flag;
		end
		if (s.last)
			blocked_flag = 1'b0;
		return v;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic logic signed [31:0] near_coord(logic signed [31:0] c);
		return c + 32'(int'($urandom_range(160)) - 80);
	endfunction

	function automatic logic signed [31:0] corner_value();
		case ($urandom_range(3))
			0: return C_MIN;
			1: return C_MAX;
			2: return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	// Random occluder, biased toward the geometry of the current sight line so
	// that crossings, touches and collinear overlaps all come up often.
	function automatic seg_req_t random_segment(logic last);
		seg_req_t           s;
		logic signed [31:0] dx, dy, mx, my;
		int                 k1, k2;
		dx        = tgt_x - obs_x;
		dy        = tgt_y - obs_y;
		mx        = obs_x + (dx >>> 1);
		my        = obs_y + (dy >>> 1);
		s.present = 1'b1;
		s.last    = last;
		s.sx      = near_coord(mx);
		s.sy      = near_coord(my);
		s.ex      = near_coord(mx);
		s.ey      = near_coord(my);
		k1        = int'($urandom_range(3)) - 1;
		k2        = int'($urandom_range(3)) - 1;
		case ($urandom_range(9))
			0: begin
				// empty request with garbage coordinates
				s.present = 1'b0;
				s.sx      = $urandom;
				s.sy      = $urandom;
				s.ex      = $urandom;
				s.ey      = $urandom;
			end
			1: begin
				s.sx = $urandom;
				s.sy = $urandom;
				s.ex = $urandom;
				s.ey = $urandom;
			end
			2: begin
				s.sx = corner_value();
				s.sy = corner_value();
				s.ex = corner_value();
				s.ey = corner_value();
			end
			3: begin
				// endpoints on the sight line at whole multiples of its length
				s.sx = obs_x + k1 * dx;
				s.sy = obs_y + k1 * dy;
				s.ex = obs_x + k2 * dx;
				s.ey = obs_y + k2 * dy;
			end
			4: begin
				if ($urandom_range(1)) begin
					s.sx = obs_x;
					s.sy = obs_y;
				end else begin
					s.sx = tgt_x;
					s.sy = tgt_y;
				end
			end
			5: begin
				s.ex = s.sx;
				s.ey = s.sy;
			end
			6: begin
				// perpendicular through the midpoint, either or both arms possibly zero
				s.sx = mx - k1 * dy;
				s.sy = my + k1 * dx;
				s.ex = mx + (k2 + 1) * dy;
				s.ey = my - (k2 + 1) * dx;
			end
			default: ;
		endcase
		return s;
	endfunction

	// ---------------------------------------------------------------------
	// Bus tasks
	// ---------------------------------------------------------------------

	// Setup phase, access phase, then drop the select.
	task automatic write_register(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_BITS'({idx, 2'b00});
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_OBSERVER_X:   obs_x = value;
			REG_OBSERVER_Y:   obs_y = value;
			REG_TARGET_X:     tgt_x = value;
			REG_TARGET_Y:     tgt_y = value;
			REG_SIGHT_RADIUS: sight_radius = value[30:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic load_random_geometry(int unsigned kind);
		logic [31:0] ox, oy, tx, ty, rad;
		case (kind)
			0: begin
				// small coordinates, radius around the sight distance or the widest one
				ox  = near_coord(0);
				oy  = near_coord(0);
				tx  = near_coord(0);
				ty  = near_coord(0);
				rad = ($urandom_range(3) == 0) ? 32'h7FFF_FFFF : $urandom_range(200);
			end
			1: begin
				ox  = $urandom;
				oy  = $urandom;
				tx  = $urandom;
				ty  = $urandom;
				rad = $urandom;
			end
			2: begin
				// observer on the target
				ox  = $urandom_range(1) ? $urandom : near_coord(0);
				oy  = $urandom_range(1) ? $urandom : near_coord(0);
				tx  = ox;
				ty  = oy;
				rad = $urandom;
			end
			default: begin
				ox  = corner_value();
				oy  = corner_value();
				tx  = corner_value();
				ty  = corner_value();
				rad = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
			end
		endcase
		write_register(REG_OBSERVER_X, ox);
		write_register(REG_OBSERVER_Y, oy);
		write_register(REG_TARGET_X, tx);
		write_register(REG_TARGET_Y, ty);
		write_register(REG_SIGHT_RADIUS, rad);
	endtask

	// ---------------------------------------------------------------------
	// Request channel
	// ---------------------------------------------------------------------

	// Offer one request after an optional gap and hold it until accepted; the
	// verdict is queued at the accepting edge so it sees the current registers.
	task automatic send_request(seg_req_t req, logic typed, verdict_t typed_verdict);
		verdict_t predicted;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			seg_ch.valid = 1'b0;
			@(negedge clk);
		end
		seg_ch.seg_start_x     = req.sx;
		seg_ch.seg_start_y     = req.sy;
		seg_ch.seg_end_x       = req.ex;
		seg_ch.seg_end_y       = req.ey;
		seg_ch.segment_present = req.present;
		seg_ch.last_segment    = req.last;
		seg_ch.valid           = 1'b1;
		@(posedge clk);
		while (!seg_ch.ready)
			@(posedge clk);
		predicted = predict_verdict(req);
		expected_verdicts.insert(expected_verdicts.size(), typed ? typed_verdict : predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every verdict has come back.
	task automatic wait_idle();
		seg_ch.valid = 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Verdict channel: back-pressure and checking
	// ---------------------------------------------------------------------

	// Random stalls, plus one long hold-off once enough requests went in, so
	// the pipeline fills and the request side has to stall.
	initial begin : verdict_backpressure
		int  hold_left;
		bit  hold_used;
		hold_left        = 0;
		hold_used        = 1'b0;
		verdict_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_used && requests_sent >= HOLD_AFTER) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				verdict_ch.ready = 1'b0;
				hold_left--;
			end else begin
				verdict_ch.ready = ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic void note_failure(string what);
		if (mismatches < REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endfunction

	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			seen_verdict = '{verdict_ch.line_clear, verdict_ch.segment_blocks,
				verdict_ch.query_done};
			if (expected_verdicts.size() == 0) begin
				note_failure($sformatf("verdict clear=%0b blocks=%0b done=%0b with none due",
					seen_verdict.line_clear, seen_verdict.segment_blocks,
					seen_verdict.query_done));
			end else begin
				due_verdict = expected_verdicts.pop_front();
				if (seen_verdict.line_clear !== due_verdict.line_clear ||
						seen_verdict.segment_blocks !== due_verdict.segment_blocks ||
						seen_verdict.query_done !== due_verdict.query_done)
					note_failure($sformatf(
						"expected clear=%0b blocks=%0b done=%0b, got clear=%0b blocks=%0b done=%0b",
						due_verdict.line_clear, due_verdict.segment_blocks,
						due_verdict.query_done, seen_verdict.line_clear,
						seen_verdict.segment_blocks, seen_verdict.query_done));
			end
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("line_of_sight_segment_test_unit_tb: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin : main_sequence
		plan_row_t   row;
		seg_req_t    req;
		verdict_t    typed_verdict;
		int unsigned items_left;
		int unsigned qlen;
		logic        last;

		// drive every input to a known value and hold reset
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		seg_ch.valid           = 1'b0;
		seg_ch.seg_start_x     = '0;
		seg_ch.seg_start_y     = '0;
		seg_ch.seg_end_x       = '0;
		seg_ch.seg_end_y       = '0;
		seg_ch.segment_present = 1'b0;
		seg_ch.last_segment    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed plan, sender 25 % idle, receiver 77 % idle
		for (int r = 0; r < NUM_PLAN_ROWS; r++) begin
			row = DIRECTED_PLAN[r];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_register(row.idx, row.value);
			end else begin
				req           = '{row.sx, row.sy, row.ex, row.ey, row.present, row.last};
				typed_verdict = '{row.exp_clear, row.exp_blocks, row.last};
				send_request(req, row.typed, typed_verdict);
			end
		end

		// random queries: three idle patterns, five geometries each
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					src_idle_pct  = 25;
					sink_idle_pct = 77;
				end
				1: begin
					src_idle_pct  = 77;
					sink_idle_pct = 25;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int phase = 0; phase < 5; phase++) begin
				wait_idle();
				load_random_geometry((mode * 5 + phase) % 4);
				items_left = ITEMS_PER_PHASE;
				while (items_left > 0) begin
					// mostly well-formed queries; now and then a stray last flag
					qlen = $urandom_range(8, 1);
					if (qlen > items_left)
						qlen = items_left;
					for (int i = 0; i < qlen; i++) begin
						last = (i == qlen - 1);
						if ($urandom_range(19) == 0)
							last = 1'($urandom_range(1));
						send_request(random_segment(last), 1'b0, '0);
					end
					items_left -= qlen;
				end
			end
		end

		// drain, then let the pipeline settle before the verdict
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("line_of_sight_segment_test_unit_tb: PASS");
		else
			$display("line_of_sight_segment_test_unit_tb: FAIL");
		$finish;
	end

endmodule
